@@ design/mass_spring_step_macros.svh @@
// Assertion macros for the block's RTL.
// Each macro expects clk and rst_n in scope.
`ifndef MASS_SPRING_STEP_MACROS_SVH
`define MASS_SPRING_STEP_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define MSS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mass_spring_step: implication check failed");
// Next-cycle implication.
`define MSS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mass_spring_step: next-cycle check failed");
`else
`define MSS_ASSERT_IMPL(lbl, ante, cons)
`define MSS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ design/mss_pkg.sv @@
package mss_pkg;

  localparam int NODE_COUNT_DEF = 8;

  // Shared serial arithmetic unit.
  localparam int ARITH_W    = 68;
  localparam int MUL_B_W    = 24;
  localparam int MUL_STEPS  = 24;
  localparam int DIV_STEPS  = 68;
  localparam int SQRT_W     = 44;
  localparam int SQRT_STEPS = 22;
  localparam int CNT_W      = 7;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_SQRT
  } arith_op_t;

  typedef struct packed {
    logic      start;
    arith_op_t op;
  } arith_req_t;

  typedef enum logic [2:0] {
    REG_INV_MASS,
    REG_STIFFNESS,
    REG_REST_LENGTH,
    REG_DAMPING,
    REG_X_LOWER,
    REG_X_UPPER,
    REG_Y_LOWER,
    REG_Y_UPPER
  } cfg_reg_t;

  localparam logic [16:0] INV_MASS_RST = 17'd6554;
  localparam logic [23:0] STIFF_RST    = 24'd10000;
  localparam logic [20:0] REST_RST     = 21'd32768;
  localparam logic [16:0] DAMP_RST     = 17'd65470;
  localparam logic [20:0] X_LOWER_RST  = 21'd6554;
  localparam logic [20:0] X_UPPER_RST  = 21'd517734;
  localparam logic [20:0] Y_LOWER_RST  = 21'd6554;
  localparam logic [20:0] Y_UPPER_RST  = 21'd386662;

endpackage

@@ design/mss_ram.sv @@
module mss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ design/mss_arith.sv @@
// Shared serial unit: shift-add multiply one multiplier bit per cycle,
// restoring divide one quotient bit per cycle, square root one result bit
// per cycle.
module mss_arith (
  input  logic                                clk,
  input  logic                                rst_n,
  input  mss_pkg::arith_req_t                 req,
  input  logic signed [mss_pkg::ARITH_W-1:0]  a_in,
  input  logic [mss_pkg::MUL_B_W-1:0]         b_in,
  output logic                                done,
  output logic signed [mss_pkg::ARITH_W-1:0]  result
);

  localparam int AW = mss_pkg::ARITH_W;
  localparam int BW = mss_pkg::MUL_B_W;
  localparam int SW = mss_pkg::SQRT_W;
  localparam int CW = mss_pkg::CNT_W;

  logic                busy_r;
  logic                done_r;
  mss_pkg::arith_op_t  op_r;
  logic [CW-1:0]       cnt_r;
  logic [AW-1:0]       acc_r;
  logic [AW-1:0]       mcand_r;
  logic [BW-1:0]       mplier_r;
  logic [BW-1:0]       rem_r;
  logic [SW-1:0]       sq_num_r;
  logic [SW-1:0]       sq_root_r;
  logic [SW-1:0]       sq_bit_r;

  logic [BW:0]         div_shift;
  logic                div_fit;
  logic [SW-1:0]       sq_trial;
  logic                sq_fit;

  always_comb begin
    div_shift = {rem_r, acc_r[AW-1]};
    div_fit   = (div_shift >= {1'b0, mplier_r});
    sq_trial  = sq_root_r + sq_bit_r;
    sq_fit    = (sq_num_r >= sq_trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy_r) begin
        busy_r    <= 1'b1;
        op_r      <= req.op;
        mplier_r  <= b_in;
        rem_r     <= '0;
        mcand_r   <= a_in;
        sq_num_r  <= a_in[SW-1:0];
        sq_root_r <= '0;
        sq_bit_r  <= SW'(1) << (SW - 2);
        case (req.op)
          mss_pkg::OP_MUL: begin
            acc_r <= '0;
            cnt_r <= CW'(mss_pkg::MUL_STEPS - 1);
          end
          mss_pkg::OP_DIV: begin
            acc_r <= a_in;
            cnt_r <= CW'(mss_pkg::DIV_STEPS - 1);
          end
          default: begin
            acc_r <= '0;
            cnt_r <= CW'(mss_pkg::SQRT_STEPS - 1);
          end
        endcase
      end else if (busy_r) begin
        case (op_r)
          mss_pkg::OP_MUL: begin
            if (mplier_r[0]) begin
              acc_r <= acc_r + mcand_r;
            end
            mcand_r  <= mcand_r << 1;
            mplier_r <= mplier_r >> 1;
          end
          mss_pkg::OP_DIV: begin
            if (div_fit) begin
              rem_r <= BW'(div_shift - {1'b0, mplier_r});
            end else begin
              rem_r <= div_shift[BW-1:0];
            end
            acc_r <= {acc_r[AW-2:0], div_fit};
          end
          default: begin
            if (sq_fit) begin
              sq_num_r  <= sq_num_r - sq_trial;
              sq_root_r <= (sq_root_r >> 1) + sq_bit_r;
            end else begin
              sq_root_r <= sq_root_r >> 1;
            end
            sq_bit_r <= sq_bit_r >> 2;
          end
        endcase
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done   = done_r;
  assign result = (op_r == mss_pkg::OP_SQRT) ? $signed(AW'(sq_root_r)) : $signed(acc_r);

endmodule

@@ design/mass_spring_step.sv @@
// Channel  | Ports                                              | Handshake
// ---------+----------------------------------------------------+-------------------------
// input    | in_mode, in_node_index, in_partner_index, in_force_*, | start & !busy
//          | in_new_*, in_time_step                             |
// result   | out_node_out, out_pos_*, out_vel_*, out_spring_length | out_valid, one cycle
// config   | cfg_index, cfg_wdata                               | cfg_we
//
// Add force and set position pass through S_LOAD_A, S_PREP and S_WRITE_A to
// the result strobe in S_OUT. Integrate runs eight serial multiplies, a spring
// six multiplies, a square root and two divides, a zero-length spring only
// its two multiplies and the square root; all on the one shared serial unit.
// busy drops in the cycle after the strobe.
// Reset is synchronous and active low; no clearing pass is needed because
// each node carries a valid bit and reads as zero until first written.
// The receiver cannot stall: each result is shown for exactly one cycle.
`include "mass_spring_step_macros.svh"

module mass_spring_step #(
  parameter int NODE_COUNT = mss_pkg::NODE_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_mode,
  input  logic [2:0]         in_node_index,
  input  logic [2:0]         in_partner_index,
  input  logic signed [39:0] in_force_x,
  input  logic signed [39:0] in_force_y,
  input  logic [20:0]        in_new_x,
  input  logic [20:0]        in_new_y,
  input  logic [16:0]        in_time_step,
  output logic               out_valid,
  output logic [2:0]         out_node_out,
  output logic [20:0]        out_pos_x,
  output logic [20:0]        out_pos_y,
  output logic signed [31:0] out_vel_x,
  output logic signed [31:0] out_vel_y,
  output logic [20:0]        out_spring_length,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_wdata
);

  localparam int AW  = $clog2(NODE_COUNT);
  localparam int A_W = mss_pkg::ARITH_W;
  localparam int B_W = mss_pkg::MUL_B_W;

  // One record per node; the whole record is read, updated and written back.
  typedef struct packed {
    logic [20:0]        px;
    logic [20:0]        py;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [39:0] fx;
    logic signed [39:0] fy;
  } node_t;

  typedef enum logic [1:0] {
    MODE_FORCE,
    MODE_SPRING,
    MODE_INTEGRATE,
    MODE_SET_POS
  } mode_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD_A,
    S_LOAD_B,
    S_PREP,
    S_LAUNCH,
    S_WAIT,
    S_WRITE_A,
    S_WRITE_B,
    S_OUT
  } state_t;

  // Each step is one pass through the shared serial unit.
  typedef enum logic [4:0] {
    ST_FX_INV,
    ST_FY_INV,
    ST_AX_DT,
    ST_AY_DT,
    ST_VX_DAMP,
    ST_VY_DAMP,
    ST_VX_DT,
    ST_VY_DT,
    ST_SQ_X,
    ST_SQ_Y,
    ST_SQRT,
    ST_T_X,
    ST_TK_X,
    ST_DIV_X,
    ST_T_Y,
    ST_TK_Y,
    ST_DIV_Y
  } step_t;

  localparam logic [39:0] F40_MAX = 40'h7F_FFFF_FFFF;

  function automatic logic signed [39:0] sat40(input logic signed [40:0] v);
    if (v[40] != v[39]) begin
      return v[40] ? 40'sh80_0000_0000 : 40'sh7F_FFFF_FFFF;
    end
    return v[39:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [42:0] v);
    if (v > 43'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end
    if (v < -43'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  // Upper bound first, then lower bound, so the lower bound wins.
  function automatic logic [20:0] clamp(input logic signed [34:0] p,
                                        input logic [20:0] lo,
                                        input logic [20:0] hi);
    logic signed [34:0] q;
    q = p;
    if (q > $signed(35'(hi))) begin
      q = $signed(35'(hi));
    end
    if (q < $signed(35'(lo))) begin
      q = $signed(35'(lo));
    end
    return q[20:0];
  endfunction

  // Configuration registers.
  logic [16:0] inv_r;
  logic [23:0] k_r;
  logic [20:0] rest_r;
  logic [16:0] damp_r;
  logic [20:0] xl_r;
  logic [20:0] xu_r;
  logic [20:0] yl_r;
  logic [20:0] yu_r;

  // Sequencer and item registers.
  state_t             state_r;
  step_t              step_r;
  mode_t              mode_r;
  logic [2:0]         a_r;
  logic [2:0]         b_r;
  logic               a_ok_r;
  logic               b_ok_r;
  logic [16:0]        dt_r;
  logic signed [39:0] fin_x_r;
  logic signed [39:0] fin_y_r;
  logic [20:0]        nx_r;
  logic [20:0]        ny_r;
  node_t              na_r;
  node_t              nb_r;
  logic signed [40:0] ax_r;
  logic signed [40:0] ay_r;
  logic [43:0]        sum_r;
  // The span between two corners of the full position range needs 22 bits.
  logic [21:0]        len_r;
  logic [42:0]        t_r;
  logic [66:0]        tk_r;
  logic signed [40:0] fsx_r;
  logic [NODE_COUNT-1:0] valid_r;
  logic               rd_valid_r;

  // Memory and serial unit hookup.
  logic [AW-1:0]       rd_addr;
  logic                rd_in_range;
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  node_t               ram_wdata;
  node_t               ram_rdata;
  mss_pkg::arith_req_t arith_req;
  logic signed [A_W-1:0] arith_a;
  logic [B_W-1:0]      arith_b;
  logic                arith_done;
  logic signed [A_W-1:0] arith_res;

  // Spring geometry, live from the loaded records.
  logic signed [21:0] dx;
  logic signed [21:0] dy;
  logic [21:0]        adx;
  logic [21:0]        ady;
  logic signed [22:0] stretch;
  logic [22:0]        astr;
  logic [39:0]        spring_mag;
  logic               spring_neg;
  logic signed [40:0] spring_f;

  always_comb begin
    dx      = $signed({1'b0, nb_r.px}) - $signed({1'b0, na_r.px});
    dy      = $signed({1'b0, nb_r.py}) - $signed({1'b0, na_r.py});
    adx     = dx[21] ? 22'(-dx) : 22'(dx);
    ady     = dy[21] ? 22'(-dy) : 22'(dy);
    stretch = $signed({1'b0, len_r}) - $signed({2'b0, rest_r});
    astr    = stretch[22] ? 23'(-stretch) : 23'(stretch);

    // The divide result is the force magnitude, limited to the 40-bit range.
    spring_mag = (arith_res > $signed(A_W'(F40_MAX))) ? F40_MAX : arith_res[39:0];
    spring_neg = ((step_r == ST_DIV_X) ? dx[21] : dy[21]) ^ stretch[22];
    spring_f   = spring_neg ? -$signed({1'b0, spring_mag}) : $signed({1'b0, spring_mag});
  end

  always_comb begin
    rd_addr     = (state_r == S_IDLE) ? AW'(in_node_index) : AW'(b_r);
    rd_in_range = (32'(rd_addr) < NODE_COUNT);
    ram_we      = (state_r == S_WRITE_A) || (state_r == S_WRITE_B);
    ram_waddr   = (state_r == S_WRITE_B) ? AW'(b_r) : AW'(a_r);
    ram_wdata   = (state_r == S_WRITE_B) ? nb_r : na_r;
  end

  // Operand selection for the shared serial unit.
  always_comb begin
    arith_req.start = (state_r == S_LAUNCH);
    arith_req.op    = mss_pkg::OP_MUL;
    arith_a         = '0;
    arith_b         = '0;
    case (step_r)
      ST_FX_INV: begin
        arith_a = A_W'(na_r.fx);
        arith_b = B_W'(inv_r);
      end
      ST_FY_INV: begin
        arith_a = A_W'(na_r.fy);
        arith_b = B_W'(inv_r);
      end
      ST_AX_DT: begin
        arith_a = A_W'(ax_r);
        arith_b = B_W'(dt_r);
      end
      ST_AY_DT: begin
        arith_a = A_W'(ay_r);
        arith_b = B_W'(dt_r);
      end
      ST_VX_DAMP: begin
        arith_a = A_W'(na_r.vx);
        arith_b = B_W'(damp_r);
      end
      ST_VY_DAMP: begin
        arith_a = A_W'(na_r.vy);
        arith_b = B_W'(damp_r);
      end
      ST_VX_DT: begin
        arith_a = A_W'(na_r.vx);
        arith_b = B_W'(dt_r);
      end
      ST_VY_DT: begin
        arith_a = A_W'(na_r.vy);
        arith_b = B_W'(dt_r);
      end
      ST_SQ_X: begin
        arith_a = $signed(A_W'(adx));
        arith_b = B_W'(adx);
      end
      ST_SQ_Y: begin
        arith_a = $signed(A_W'(ady));
        arith_b = B_W'(ady);
      end
      ST_SQRT: begin
        arith_req.op = mss_pkg::OP_SQRT;
        arith_a      = $signed(A_W'(sum_r));
      end
      ST_T_X: begin
        arith_a = $signed(A_W'(adx));
        arith_b = B_W'(astr);
      end
      ST_T_Y: begin
        arith_a = $signed(A_W'(ady));
        arith_b = B_W'(astr);
      end
      ST_TK_X, ST_TK_Y: begin
        arith_a = $signed(A_W'(t_r));
        arith_b = k_r;
      end
      ST_DIV_X, ST_DIV_Y: begin
        arith_req.op = mss_pkg::OP_DIV;
        arith_a      = $signed(A_W'(tk_r));
        arith_b      = B_W'(len_r);
      end
      default: begin
        arith_a = '0;
      end
    endcase
  end

  mss_ram #(
    .WIDTH($bits(node_t)),
    .DEPTH(NODE_COUNT)
  ) u_node_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(rd_addr),
    .rdata(ram_rdata)
  );

  mss_arith u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (arith_req),
    .a_in  (arith_a),
    .b_in  (arith_b),
    .done  (arith_done),
    .result(arith_res)
  );

  always_ff @(posedge clk) begin
    rd_valid_r <= rd_in_range && valid_r[rd_addr];

    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= '0;
      inv_r   <= mss_pkg::INV_MASS_RST;
      k_r     <= mss_pkg::STIFF_RST;
      rest_r  <= mss_pkg::REST_RST;
      damp_r  <= mss_pkg::DAMP_RST;
      xl_r    <= mss_pkg::X_LOWER_RST;
      xu_r    <= mss_pkg::X_UPPER_RST;
      yl_r    <= mss_pkg::Y_LOWER_RST;
      yu_r    <= mss_pkg::Y_UPPER_RST;
    end else begin
      if (cfg_we) begin
        case (mss_pkg::cfg_reg_t'(cfg_index))
          mss_pkg::REG_INV_MASS:    inv_r  <= cfg_wdata[16:0];
          mss_pkg::REG_STIFFNESS:   k_r    <= cfg_wdata;
          mss_pkg::REG_REST_LENGTH: rest_r <= cfg_wdata[20:0];
          mss_pkg::REG_DAMPING:     damp_r <= cfg_wdata[16:0];
          mss_pkg::REG_X_LOWER:     xl_r   <= cfg_wdata[20:0];
          mss_pkg::REG_X_UPPER:     xu_r   <= cfg_wdata[20:0];
          mss_pkg::REG_Y_LOWER:     yl_r   <= cfg_wdata[20:0];
          mss_pkg::REG_Y_UPPER:     yu_r   <= cfg_wdata[20:0];
          default: ;
        endcase
      end

      case (state_r)
        S_IDLE: begin
          if (start) begin
            mode_r  <= mode_t'(in_mode);
            a_r     <= in_node_index;
            b_r     <= in_partner_index;
            a_ok_r  <= (32'(in_node_index) < NODE_COUNT);
            b_ok_r  <= (32'(in_partner_index) < NODE_COUNT);
            dt_r    <= in_time_step;
            fin_x_r <= in_force_x;
            fin_y_r <= in_force_y;
            nx_r    <= in_new_x;
            ny_r    <= in_new_y;
            len_r   <= '0;
            state_r <= S_LOAD_A;
          end
        end
        S_LOAD_A: begin
          // Node a arrives now; the read of node b was issued this cycle.
          na_r <= rd_valid_r ? ram_rdata : '0;
          if (a_ok_r && b_ok_r && (mode_r == MODE_SPRING)) begin
            state_r <= S_LOAD_B;
          end else begin
            state_r <= S_PREP;
          end
        end
        S_LOAD_B: begin
          nb_r    <= rd_valid_r ? ram_rdata : '0;
          state_r <= S_PREP;
        end
        S_PREP: begin
          if (!a_ok_r) begin
            state_r <= S_OUT;
          end else begin
            case (mode_r)
              MODE_FORCE: begin
                na_r.fx <= sat40(41'(na_r.fx) + 41'(fin_x_r));
                na_r.fy <= sat40(41'(na_r.fy) + 41'(fin_y_r));
                state_r <= S_WRITE_A;
              end
              MODE_SPRING: begin
                step_r  <= ST_SQ_X;
                state_r <= b_ok_r ? S_LAUNCH : S_OUT;
              end
              MODE_INTEGRATE: begin
                step_r  <= ST_FX_INV;
                state_r <= S_LAUNCH;
              end
              default: begin
                na_r.px <= nx_r;
                na_r.py <= ny_r;
                state_r <= S_WRITE_A;
              end
            endcase
          end
        end
        S_LAUNCH: begin
          state_r <= S_WAIT;
        end
        S_WAIT: begin
          if (arith_done) begin
            state_r <= S_LAUNCH;
            case (step_r)
              ST_FX_INV: begin
                ax_r   <= $signed(arith_res[56:16]);
                step_r <= ST_FY_INV;
              end
              ST_FY_INV: begin
                ay_r   <= $signed(arith_res[56:16]);
                step_r <= ST_AX_DT;
              end
              ST_AX_DT: begin
                na_r.vx <= sat32(43'(na_r.vx) + 43'($signed(arith_res[57:16])));
                step_r  <= ST_AY_DT;
              end
              ST_AY_DT: begin
                na_r.vy <= sat32(43'(na_r.vy) + 43'($signed(arith_res[57:16])));
                step_r  <= ST_VX_DAMP;
              end
              ST_VX_DAMP: begin
                na_r.vx <= sat32(43'($signed(arith_res[48:16])));
                step_r  <= ST_VY_DAMP;
              end
              ST_VY_DAMP: begin
                na_r.vy <= sat32(43'($signed(arith_res[48:16])));
                step_r  <= ST_VX_DT;
              end
              ST_VX_DT: begin
                na_r.px <= clamp($signed({14'd0, na_r.px}) +
                                 35'($signed(arith_res[48:16])), xl_r, xu_r);
                step_r  <= ST_VY_DT;
              end
              ST_VY_DT: begin
                na_r.py <= clamp($signed({14'd0, na_r.py}) +
                                 35'($signed(arith_res[48:16])), yl_r, yu_r);
                na_r.fx <= '0;
                na_r.fy <= '0;
                state_r <= S_WRITE_A;
              end
              ST_SQ_X: begin
                sum_r  <= arith_res[43:0];
                step_r <= ST_SQ_Y;
              end
              ST_SQ_Y: begin
                sum_r  <= sum_r + arith_res[43:0];
                step_r <= ST_SQRT;
              end
              ST_SQRT: begin
                // A zero-length spring leaves both nodes untouched.
                len_r  <= arith_res[21:0];
                step_r <= ST_T_X;
                if (arith_res == '0) begin
                  state_r <= S_OUT;
                end
              end
              ST_T_X: begin
                t_r    <= arith_res[42:0];
                step_r <= ST_TK_X;
              end
              ST_TK_X: begin
                tk_r   <= arith_res[66:0];
                step_r <= ST_DIV_X;
              end
              ST_DIV_X: begin
                fsx_r  <= spring_f;
                step_r <= ST_T_Y;
              end
              ST_T_Y: begin
                t_r    <= arith_res[42:0];
                step_r <= ST_TK_Y;
              end
              ST_TK_Y: begin
                tk_r   <= arith_res[66:0];
                step_r <= ST_DIV_Y;
              end
              ST_DIV_Y: begin
                // Equal and opposite forces on the two ends.
                na_r.fx <= sat40(41'(na_r.fx) + fsx_r);
                na_r.fy <= sat40(41'(na_r.fy) + spring_f);
                nb_r.fx <= sat40(41'(nb_r.fx) - fsx_r);
                nb_r.fy <= sat40(41'(nb_r.fy) - spring_f);
                state_r <= S_WRITE_A;
              end
              default: begin
                state_r <= S_OUT;
              end
            endcase
          end
        end
        S_WRITE_A: begin
          valid_r[AW'(a_r)] <= 1'b1;
          state_r <= (mode_r == MODE_SPRING) ? S_WRITE_B : S_OUT;
        end
        S_WRITE_B: begin
          valid_r[AW'(b_r)] <= 1'b1;
          state_r <= S_OUT;
        end
        S_OUT: begin
          state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy              = (state_r != S_IDLE);
  assign out_valid         = (state_r == S_OUT);
  assign out_node_out      = a_r;
  assign out_pos_x         = a_ok_r ? na_r.px : '0;
  assign out_pos_y         = a_ok_r ? na_r.py : '0;
  assign out_vel_x         = a_ok_r ? na_r.vx : '0;
  assign out_vel_y         = a_ok_r ? na_r.vy : '0;
  assign out_spring_length = len_r[20:0];

  // The serial unit only reports completion while the sequencer waits on it.
  `MSS_ASSERT_IMPL(a_done_in_wait, arith_done, state_r == S_WAIT)
  // A result strobe always closes the item and frees the block.
  `MSS_ASSERT_NEXT(a_out_frees, out_valid, !busy)
  // Node writes only go to nodes inside the table.
  `MSS_ASSERT_IMPL(a_write_in_range, ram_we, 32'(ram_waddr) < NODE_COUNT)

endmodule

@@ tb/tb_pkg.sv @@
`timescale 1ns / 100ps

package tb_pkg;

  // Operation codes carried by in_mode.
  typedef enum logic [1:0] {
    MODE_FORCE,
    MODE_SPRING,
    MODE_INTEGRATE,
    MODE_SET_POS
  } node_mode_t;

endpackage

@@ tb/mss_checker.sv @@
`timescale 1ns / 100ps

module mss_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic [1:0]         in_mode,
  input  logic [2:0]         in_node_index,
  input  logic [2:0]         in_partner_index,
  input  logic signed [39:0] in_force_x,
  input  logic signed [39:0] in_force_y,
  input  logic [20:0]        in_new_x,
  input  logic [20:0]        in_new_y,
  input  logic [16:0]        in_time_step,
  input  logic               out_valid,
  input  logic [2:0]         out_node_out,
  input  logic [20:0]        out_pos_x,
  input  logic [20:0]        out_pos_y,
  input  logic signed [31:0] out_vel_x,
  input  logic signed [31:0] out_vel_y,
  input  logic [20:0]        out_spring_length,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_wdata,
  output int                 fail_count,
  output int                 pending
);

  localparam int NODES = 8;
  localparam longint F40_MAX = 64'sd549755813887;
  localparam longint F40_MIN = -64'sd549755813888;
  localparam longint V32_MAX = 64'sd2147483647;
  localparam longint V32_MIN = -64'sd2147483648;

  typedef struct {
    logic [2:0]         node;
    logic [20:0]        px;
    logic [20:0]        py;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic [20:0]        len;
  } node_report_t;

  node_report_t reports_due[$];

  logic [16:0] inv_mass, damping;
  logic [23:0] stiffness;
  logic [20:0] rest_len, x_lo, x_hi, y_lo, y_hi;
  longint pos_x[NODES], pos_y[NODES], vel_x[NODES], vel_y[NODES];
  longint acc_x[NODES], acc_y[NODES];

  function automatic longint clip(longint v, longint lo, longint hi);
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Hooke force on one axis, truncated toward zero and limited in magnitude.
  function automatic longint hooke_axis(longint delta, longint stretch,
                                        longint unsigned span);
    bit neg;
    longint unsigned t, q, r, f, k;
    longint m;
    neg = (delta < 0) != (stretch < 0);
    k = stiffness;
    t = longint'(delta < 0 ? -delta : delta) * longint'(stretch < 0 ? -stretch : stretch);
    q = t / span;
    r = t % span;
    f = q * k + (r * k) / span;
    m = (f > F40_MAX) ? F40_MAX : longint'(f);
    return neg ? -m : m;
  endfunction

  function automatic longint box(longint p, longint lo, longint hi);
    if (p > hi) p = hi;
    if (p < lo) p = lo;
    return p;
  endfunction

  // Apply one command to the node table and return the report it produces.
  function automatic node_report_t advance_nodes(logic [1:0] mode, int a, int b,
      logic signed [39:0] fx_in, logic signed [39:0] fy_in,
      logic [20:0] nx, logic [20:0] ny, logic [16:0] dt_in);
    node_report_t rep;
    longint dx, dy, stretch, fx, fy, ax, ay, vx, vy, dt;
    longint unsigned len;
    len = 0;
    dt = dt_in;
    case (tb_pkg::node_mode_t'(mode))
      tb_pkg::MODE_FORCE: begin
        acc_x[a] = clip(acc_x[a] + longint'(fx_in), F40_MIN, F40_MAX);
        acc_y[a] = clip(acc_y[a] + longint'(fy_in), F40_MIN, F40_MAX);
      end
      tb_pkg::MODE_SPRING: begin
        dx = pos_x[b] - pos_x[a];
        dy = pos_y[b] - pos_y[a];
        len = int_sqrt(longint'(dx * dx) + longint'(dy * dy));
        // A spring of zero length, including one from a node to itself, pushes nothing.
        if (len != 0) begin
          stretch = longint'(len) - longint'(rest_len);
          fx = hooke_axis(dx, stretch, len);
          fy = hooke_axis(dy, stretch, len);
          acc_x[a] = clip(acc_x[a] + fx, F40_MIN, F40_MAX);
          acc_y[a] = clip(acc_y[a] + fy, F40_MIN, F40_MAX);
          acc_x[b] = clip(acc_x[b] - fx, F40_MIN, F40_MAX);
          acc_y[b] = clip(acc_y[b] - fy, F40_MIN, F40_MAX);
        end
      end
      tb_pkg::MODE_INTEGRATE: begin
        ax = (acc_x[a] * longint'(inv_mass)) >>> 16;
        ay = (acc_y[a] * longint'(inv_mass)) >>> 16;
        acc_x[a] = 0;
        acc_y[a] = 0;
        vx = clip(vel_x[a] + ((ax * dt) >>> 16), V32_MIN, V32_MAX);
        vy = clip(vel_y[a] + ((ay * dt) >>> 16), V32_MIN, V32_MAX);
        vx = clip((vx * longint'(damping)) >>> 16, V32_MIN, V32_MAX);
        vy = clip((vy * longint'(damping)) >>> 16, V32_MIN, V32_MAX);
        vel_x[a] = vx;
        vel_y[a] = vy;
        pos_x[a] = box(pos_x[a] + ((vx * dt) >>> 16), x_lo, x_hi);
        pos_y[a] = box(pos_y[a] + ((vy * dt) >>> 16), y_lo, y_hi);
      end
      default: begin
        pos_x[a] = nx;
        pos_y[a] = ny;
      end
    endcase
    rep.node = a[2:0];
    rep.px = pos_x[a][20:0];
    rep.py = pos_y[a][20:0];
    rep.vx = vel_x[a][31:0];
    rep.vy = vel_y[a][31:0];
    rep.len = len[20:0];
    return rep;
  endfunction

  always @(posedge clk) begin
    node_report_t want;
    if (!rst_n) begin
      inv_mass <= mss_pkg::INV_MASS_RST;
      stiffness <= mss_pkg::STIFF_RST;
      rest_len <= mss_pkg::REST_RST;
      damping <= mss_pkg::DAMP_RST;
      x_lo <= mss_pkg::X_LOWER_RST;
      x_hi <= mss_pkg::X_UPPER_RST;
      y_lo <= mss_pkg::Y_LOWER_RST;
      y_hi <= mss_pkg::Y_UPPER_RST;
      for (int i = 0; i < NODES; i++) begin
        pos_x[i] = 0; pos_y[i] = 0; vel_x[i] = 0; vel_y[i] = 0;
        acc_x[i] = 0; acc_y[i] = 0;
      end
      reports_due.delete();
      fail_count <= 0;
      pending <= 0;
    end else begin
      if (cfg_we) begin
        case (mss_pkg::cfg_reg_t'(cfg_index))
          mss_pkg::REG_INV_MASS:    inv_mass <= cfg_wdata[16:0];
          mss_pkg::REG_STIFFNESS:   stiffness <= cfg_wdata;
          mss_pkg::REG_REST_LENGTH: rest_len <= cfg_wdata[20:0];
          mss_pkg::REG_DAMPING:     damping <= cfg_wdata[16:0];
          mss_pkg::REG_X_LOWER:     x_lo <= cfg_wdata[20:0];
          mss_pkg::REG_X_UPPER:     x_hi <= cfg_wdata[20:0];
          mss_pkg::REG_Y_LOWER:     y_lo <= cfg_wdata[20:0];
          default:                  y_hi <= cfg_wdata[20:0];
        endcase
      end
      if (start && !busy)
        reports_due.insert(reports_due.size(),
            advance_nodes(in_mode, in_node_index, in_partner_index,
            in_force_x, in_force_y, in_new_x, in_new_y, in_time_step));
      if (out_valid) begin
        if (reports_due.size() == 0) begin
          $display("%0t: result for node %0d with no transfer waiting", $time, out_node_out);
          fail_count <= fail_count + 1;
        end else begin
          want = reports_due.pop_front();
          if (want.node !== out_node_out || want.px !== out_pos_x ||
              want.py !== out_pos_y || want.vx !== out_vel_x ||
              want.vy !== out_vel_y || want.len !== out_spring_length) begin
            $display("%0t: mismatch expected node %0d pos %0d,%0d vel %0d,%0d len %0d",
                     $time, want.node, want.px, want.py, want.vx, want.vy, want.len);
            $display("%0t:            actual node %0d pos %0d,%0d vel %0d,%0d len %0d",
                     $time, out_node_out, out_pos_x, out_pos_y, out_vel_x, out_vel_y,
                     out_spring_length);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= reports_due.size();
    end
  end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

  // The slowest correct run is about 1100 springs plus gaps; the limit is
  // several times that.
  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE_CYCLES = 400;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         in_mode = '0;
  logic [2:0]         in_node_index = '0;
  logic [2:0]         in_partner_index = '0;
  logic signed [39:0] in_force_x = '0;
  logic signed [39:0] in_force_y = '0;
  logic [20:0]        in_new_x = '0;
  logic [20:0]        in_new_y = '0;
  logic [16:0]        in_time_step = '0;
  logic               out_valid;
  logic [2:0]         out_node_out;
  logic [20:0]        out_pos_x, out_pos_y, out_spring_length;
  logic signed [31:0] out_vel_x, out_vel_y;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [23:0]        cfg_wdata = '0;
  int                 fail_count, pending;
  int                 cycles = 0;
  bit                 steady = 1'b0;  // when set, the sender never pauses

  always #4 clk = ~clk;

  mass_spring_step dut (.*);

  mss_checker u_checker (.*);

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Present one command and hold it until a transfer takes place. busy is
  // sampled at the falling edge so the decision never races the block.
  task automatic send_cmd(tb_pkg::node_mode_t mode, int a, int b,
                          logic signed [39:0] fx, logic signed [39:0] fy,
                          logic [20:0] nx, logic [20:0] ny, logic [16:0] dt);
    int gap;
    start <= 1'b1;
    in_mode <= mode;
    in_node_index <= 3'(a);
    in_partner_index <= 3'(b);
    in_force_x <= fx;
    in_force_y <= fy;
    in_new_x <= nx;
    in_new_y <= ny;
    in_time_step <= dt;
    do @(negedge clk); while (busy);
    @(posedge clk);
    // Random idle time after the transfer; start only drops when a gap follows.
    if (!steady && $urandom_range(99) < 21) begin
      gap = $urandom_range(1, 6);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_reg(mss_pkg::cfg_reg_t idx, logic [23:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // Stop sending, let every report arrive, then let the block settle.
  task automatic drain();
    start <= 1'b0;
    cfg_we <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Forces of every magnitude: a random 64-bit word shifted down a random amount.
  function automatic logic signed [39:0] rand_force();
    logic signed [63:0] w;
    w = {$urandom, $urandom};
    case ($urandom_range(9))
      0: return 40'sh7FFFFFFFFF;
      1: return -40'sh8000000000;
      default: return 40'(w >>> $urandom_range(24, 63));
    endcase
  endfunction

  function automatic logic [20:0] rand_pos();
    if ($urandom_range(9) == 0) return 21'($urandom);
    return 21'($urandom_range(0, 600000));
  endfunction

  function automatic logic [16:0] rand_dt();
    case ($urandom_range(9))
      0: return 17'($urandom);
      1: return 17'd65536;
      default: return 17'($urandom_range(0, 4000));
    endcase
  endfunction

  task automatic random_cmds(int count);
    int roll;
    for (int n = 0; n < count; n++) begin
      steady = (n >= count / 3) && (n < count / 2);
      roll = $urandom_range(99);
      if (roll < 25)
        send_cmd(tb_pkg::MODE_FORCE, $urandom_range(7), $urandom_range(7), rand_force(),
                 rand_force(), 21'($urandom), 21'($urandom), 17'($urandom));
      else if (roll < 55)
        send_cmd(tb_pkg::MODE_SPRING, $urandom_range(7), $urandom_range(7), rand_force(),
                 rand_force(), 21'($urandom), 21'($urandom), 17'($urandom));
      else if (roll < 80)
        send_cmd(tb_pkg::MODE_INTEGRATE, $urandom_range(7), $urandom_range(7),
                 rand_force(), rand_force(), 21'($urandom), 21'($urandom), rand_dt());
      else
        send_cmd(tb_pkg::MODE_SET_POS, $urandom_range(7), $urandom_range(7),
                 rand_force(), rand_force(), rand_pos(), rand_pos(), 17'($urandom));
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part under the reset settings.
    send_cmd(tb_pkg::MODE_SET_POS, 0, 0, 0, 0, 21'd100000, 21'd100000, 0);
    send_cmd(tb_pkg::MODE_SET_POS, 1, 0, 0, 0, 21'd200000, 21'd150000, 0);
    send_cmd(tb_pkg::MODE_SET_POS, 7, 0, 0, 0, 21'h1FFFFF, 21'h1FFFFF, 0);
    send_cmd(tb_pkg::MODE_SPRING, 0, 1, 0, 0, 0, 0, 0);
    send_cmd(tb_pkg::MODE_SPRING, 2, 2, 0, 0, 0, 0, 0);      // a node to itself
    send_cmd(tb_pkg::MODE_SPRING, 3, 4, 0, 0, 0, 0, 0);      // two nodes at one place
    send_cmd(tb_pkg::MODE_SPRING, 0, 7, 0, 0, 0, 0, 0);      // longest span
    send_cmd(tb_pkg::MODE_INTEGRATE, 0, 0, 0, 0, 0, 0, 17'd655);
    send_cmd(tb_pkg::MODE_INTEGRATE, 1, 0, 0, 0, 0, 0, 17'd65536);
    // Accumulator saturation at both ends.
    send_cmd(tb_pkg::MODE_FORCE, 5, 0, 40'sh7FFFFFFFFF, -40'sh8000000000, 0, 0, 0);
    send_cmd(tb_pkg::MODE_FORCE, 5, 0, 40'sh7FFFFFFFFF, -40'sh8000000000, 0, 0, 0);
    send_cmd(tb_pkg::MODE_INTEGRATE, 5, 0, 0, 0, 0, 0, 17'h1FFFF);
    send_cmd(tb_pkg::MODE_FORCE, 6, 0, -40'sh8000000000, 40'sh7FFFFFFFFF, 0, 0, 0);
    send_cmd(tb_pkg::MODE_INTEGRATE, 6, 0, 0, 0, 0, 0, 17'd0);
    drain();

    // Extreme settings: heavy drive so velocity saturates; clamp box inverted on x.
    write_reg(mss_pkg::REG_INV_MASS, 24'd65536);
    write_reg(mss_pkg::REG_STIFFNESS, 24'hFFFFFF);
    write_reg(mss_pkg::REG_REST_LENGTH, 24'd1048576);
    write_reg(mss_pkg::REG_DAMPING, 24'd65536);
    write_reg(mss_pkg::REG_X_LOWER, 24'd1048576);
    write_reg(mss_pkg::REG_X_UPPER, 24'd0);
    write_reg(mss_pkg::REG_Y_LOWER, 24'd0);
    write_reg(mss_pkg::REG_Y_UPPER, 24'd1048576);
    cfg_we <= 1'b0;
    send_cmd(tb_pkg::MODE_FORCE, 3, 0, 40'sh7FFFFFFFFF, -40'sh8000000000, 0, 0, 0);
    send_cmd(tb_pkg::MODE_INTEGRATE, 3, 0, 0, 0, 0, 0, 17'd65536);
    send_cmd(tb_pkg::MODE_FORCE, 3, 0, 40'sh7FFFFFFFFF, -40'sh8000000000, 0, 0, 0);
    send_cmd(tb_pkg::MODE_INTEGRATE, 3, 0, 0, 0, 0, 0, 17'd65536);
    send_cmd(tb_pkg::MODE_SPRING, 0, 1, 0, 0, 0, 0, 0);
    send_cmd(tb_pkg::MODE_SPRING, 1, 7, 0, 0, 0, 0, 0);
    random_cmds(150);
    drain();

    // Zero settings, then several random ones.
    for (int phase = 0; phase < 6; phase++) begin
      if (phase == 0) begin
        write_reg(mss_pkg::REG_INV_MASS, 24'd0);
        write_reg(mss_pkg::REG_STIFFNESS, 24'd0);
        write_reg(mss_pkg::REG_REST_LENGTH, 24'd0);
        write_reg(mss_pkg::REG_DAMPING, 24'd0);
        write_reg(mss_pkg::REG_X_LOWER, 24'd0);
        write_reg(mss_pkg::REG_X_UPPER, 24'h1FFFFF);
        write_reg(mss_pkg::REG_Y_LOWER, 24'd0);
        write_reg(mss_pkg::REG_Y_UPPER, 24'h1FFFFF);
      end else begin
        write_reg(mss_pkg::REG_INV_MASS, 24'($urandom_range(0, 131071)));
        write_reg(mss_pkg::REG_STIFFNESS,
                  ($urandom_range(3) == 0) ? 24'($urandom)
                                           : 24'($urandom_range(0, 50000)));
        write_reg(mss_pkg::REG_REST_LENGTH, 24'($urandom_range(0, 2097151)));
        write_reg(mss_pkg::REG_DAMPING, 24'($urandom_range(60000, 131071)));
        write_reg(mss_pkg::REG_X_LOWER, 24'($urandom_range(0, 100000)));
        write_reg(mss_pkg::REG_X_UPPER, 24'($urandom_range(300000, 2097151)));
        write_reg(mss_pkg::REG_Y_LOWER, 24'($urandom_range(0, 100000)));
        write_reg(mss_pkg::REG_Y_UPPER, 24'($urandom_range(300000, 2097151)));
      end
      cfg_we <= 1'b0;
      random_cmds(155);
      drain();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
